FILE: hw/rtl/sha256bs_pkg.sv
// ----------------------------------------------------------------------------
// sha256bs_pkg
// Shared types, constants and SHA-256 functions for the byte stream hasher.
// ----------------------------------------------------------------------------
package sha256bs_pkg;

    localparam int unsigned WordWidth     = 32;
    localparam int unsigned BlockWords    = 16;
    localparam int unsigned HashWords     = 8;
    localparam int unsigned RoundCount    = 64;
    localparam int unsigned LengthStart   = 56;
    localparam int unsigned BlockCntWidth = 55;

    localparam logic [7:0] PadByte = 8'h80;

    typedef logic [WordWidth-1:0] word_t;

    // commands for the block / message schedule window
    typedef struct packed {
        logic write_byte;
        logic pad_fill;
        logic clear_all;
        logic put_length;
        logic shift;
    } sched_ctrl_t;

    // commands for the round datapath and hash words
    typedef struct packed {
        logic load;
        logic step;
        logic update;
        logic init;
    } core_ctrl_t;

    // round constants
    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    // initial hash values
    function automatic word_t initial_hash(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    // round sigma functions
    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // message schedule sigma functions
    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

FILE: hw/rtl/sha256bs_sched.sv
// ----------------------------------------------------------------------------
// sha256bs_sched
// Message block and schedule window: packs bytes big-endian, applies the
// padding and length, and slides one schedule word per round.
// ----------------------------------------------------------------------------
module sha256bs_sched (
    input  logic                      clk,
    input  sha256bs_pkg::sched_ctrl_t ctrl,
    input  logic [5:0]                byte_pos,
    input  logic [7:0]                data_byte,
    input  logic [63:0]               total_bits,
    output sha256bs_pkg::word_t       round_word
);
    import sha256bs_pkg::*;

    word_t window_reg  [BlockWords];
    word_t window_next [BlockWords];
    word_t sched_word;

    // next schedule word from the taps of the window
    assign sched_word = small_sigma1(window_reg[14]) + window_reg[9]
                      + small_sigma0(window_reg[1]) + window_reg[0];

    assign round_word = window_reg[0];

    // byte writes, padding, length and shift
    always_comb
    begin
        logic [5:0] slot;
        for (int w = 0; w < BlockWords; w++)
        begin
            window_next[w] = window_reg[w];
        end
        for (int w = 0; w < BlockWords; w++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                slot = 6'(w * 4 + b);
                if (ctrl.write_byte && slot == byte_pos)
                begin
                    window_next[w][8*(3-b) +: 8] = data_byte;
                end
                if (ctrl.pad_fill)
                begin
                    if (slot == byte_pos)
                    begin
                        window_next[w][8*(3-b) +: 8] = PadByte;
                    end
                    else if (slot > byte_pos)
                    begin
                        window_next[w][8*(3-b) +: 8] = 8'h00;
                    end
                end
            end
        end
        if (ctrl.clear_all)
        begin
            for (int w = 0; w < BlockWords; w++)
            begin
                window_next[w] = '0;
            end
        end
        if (ctrl.put_length)
        begin
            window_next[14] = total_bits[63:32];
            window_next[15] = total_bits[31:0];
        end
        if (ctrl.shift)
        begin
            for (int w = 0; w < BlockWords - 1; w++)
            begin
                window_next[w] = window_reg[w+1];
            end
            window_next[BlockWords-1] = sched_word;
        end
    end

    // window storage
    always_ff @(posedge clk)
    begin
        for (int w = 0; w < BlockWords; w++)
        begin
            window_reg[w] <= window_next[w];
        end
    end

endmodule

FILE: hw/rtl/sha256bs_core.sv
// ----------------------------------------------------------------------------
// sha256bs_core
// Shared SHA-256 round unit: eight working words stepped once per cycle while
// step is set, plus the eight hash words and their end-of-block update.
// ----------------------------------------------------------------------------
module sha256bs_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha256bs_pkg::core_ctrl_t ctrl,
    input  logic [5:0]               round_idx,
    input  sha256bs_pkg::word_t      round_word,
    input  logic [2:0]               word_idx,
    output sha256bs_pkg::word_t      hash_word
);
    import sha256bs_pkg::*;

    word_t hash_reg [HashWords];
    word_t var_reg  [HashWords];
    word_t t1;
    word_t t2;

    // one compression round
    assign t1 = var_reg[7] + big_sigma1(var_reg[4])
              + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
              + round_k(round_idx) + round_word;
    assign t2 = big_sigma0(var_reg[0])
              + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                 ^ (var_reg[1] & var_reg[2]));

    assign hash_word = hash_reg[word_idx];

    // hash words: initial values, end-of-block add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HashWords; i++)
            begin
                hash_reg[i] <= initial_hash(3'(i));
            end
        end
        else if (ctrl.init)
        begin
            for (int i = 0; i < HashWords; i++)
            begin
                hash_reg[i] <= initial_hash(3'(i));
            end
        end
        else if (ctrl.update)
        begin
            for (int i = 0; i < HashWords; i++)
            begin
                hash_reg[i] <= hash_reg[i] + var_reg[i];
            end
        end
    end

    // working words a..h
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < HashWords; i++)
            begin
                var_reg[i] <= hash_reg[i];
            end
        end
        else if (ctrl.step)
        begin
            var_reg[7] <= var_reg[6];
            var_reg[6] <= var_reg[5];
            var_reg[5] <= var_reg[4];
            var_reg[4] <= var_reg[3] + t1;
            var_reg[3] <= var_reg[2];
            var_reg[2] <= var_reg[1];
            var_reg[1] <= var_reg[0];
            var_reg[0] <= t1 + t2;
        end
    end

endmodule

FILE: hw/rtl/sha256_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit
// SHA-256 hasher fed one message byte per word, emitting the 8-word digest.
// ----------------------------------------------------------------------------
// A data byte (op 0) is taken while in_stall is low. The 64th byte of a block
// starts a compression on the shared round unit: the rounds, then the hash
// add, during which in_stall is high. A finish (op 1) pads the block and
// compresses it; when 56 or more bytes were pending, a second block with the
// length follows (a load state, then another compression). The eight digest
// words then leave one per cycle while out_stall is low, word 0 first, and
// in_stall drops after the eighth word is taken. After a finish the hasher
// is back at its initial state for the next message.
module sha256_byte_stream_hasher_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [7:0]          data_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output sha256bs_pkg::word_t digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);
    import sha256bs_pkg::*;

    localparam logic [2:0] StIdle   = 3'd0;
    localparam logic [2:0] StRound  = 3'd1;
    localparam logic [2:0] StUpdate = 3'd2;
    localparam logic [2:0] StPadLen = 3'd3;
    localparam logic [2:0] StEmit   = 3'd4;

    localparam logic [1:0] KindData = 2'd0;
    localparam logic [1:0] KindPad1 = 2'd1;
    localparam logic [1:0] KindLast = 2'd2;

    localparam logic OpAbsorb = 1'b0;
    localparam logic OpFinish = 1'b1;

    logic [2:0]               state_reg,     state_next;
    logic [1:0]               kind_reg,      kind_next;
    logic [5:0]               round_cnt_reg, round_cnt_next;
    logic [2:0]               word_idx_reg,  word_idx_next;
    logic [5:0]               pos_reg,       pos_next;
    logic [BlockCntWidth-1:0] block_cnt_reg, block_cnt_next;

    logic        in_accept;
    logic        out_accept;
    logic        pos_short;
    logic [63:0] total_bits;
    word_t       round_word;
    word_t       hash_word;
    sched_ctrl_t sched_ctrl;
    core_ctrl_t  core_ctrl;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign pos_short  = pos_reg < 6'(LengthStart);
    assign total_bits = {block_cnt_reg, pos_reg, 3'b000};

    // handshake and output word
    assign in_stall    = state_reg != StIdle;
    assign out_valid   = state_reg == StEmit;
    assign digest_word = hash_word;
    assign word_index  = word_idx_reg;
    assign last_word   = word_idx_reg == 3'(HashWords - 1);

    // datapath commands
    always_comb
    begin
        sched_ctrl.write_byte = in_accept && op == OpAbsorb;
        sched_ctrl.pad_fill   = in_accept && op == OpFinish;
        sched_ctrl.clear_all  = state_reg == StPadLen;
        sched_ctrl.put_length = (in_accept && op == OpFinish && pos_short)
                             || state_reg == StPadLen;
        sched_ctrl.shift      = state_reg == StRound;

        core_ctrl.load   = (in_accept && (op == OpFinish || pos_reg == 6'd63))
                        || state_reg == StPadLen;
        core_ctrl.step   = state_reg == StRound;
        core_ctrl.update = state_reg == StUpdate;
        core_ctrl.init   = state_reg == StEmit && out_accept && last_word;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        round_cnt_next = round_cnt_reg;
        word_idx_next  = word_idx_reg;
        pos_next       = pos_reg;
        block_cnt_next = block_cnt_reg;
        unique case (state_reg)
            StIdle:
            begin
                round_cnt_next = '0;
                if (in_accept)
                begin
                    if (op == OpAbsorb)
                    begin
                        pos_next = pos_reg + 6'd1;
                        if (pos_reg == 6'd63)
                        begin
                            kind_next  = KindData;
                            state_next = StRound;
                        end
                    end
                    else
                    begin
                        kind_next  = pos_short ? KindLast : KindPad1;
                        state_next = StRound;
                    end
                end
            end
            StRound:
            begin
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == 6'(RoundCount - 1))
                begin
                    state_next = StUpdate;
                end
            end
            StUpdate:
            begin
                round_cnt_next = '0;
                word_idx_next  = '0;
                case (kind_reg)
                    KindData:
                    begin
                        block_cnt_next = block_cnt_reg + BlockCntWidth'(1);
                        state_next     = StIdle;
                    end
                    KindPad1:
                    begin
                        state_next = StPadLen;
                    end
                    default:
                    begin
                        state_next = StEmit;
                    end
                endcase
            end
            StPadLen:
            begin
                kind_next  = KindLast;
                state_next = StRound;
            end
            StEmit:
            begin
                if (out_accept)
                begin
                    word_idx_next = word_idx_reg + 3'd1;
                    if (last_word)
                    begin
                        pos_next       = '0;
                        block_cnt_next = '0;
                        state_next     = StIdle;
                    end
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            kind_reg      <= KindData;
            round_cnt_reg <= '0;
            word_idx_reg  <= '0;
            pos_reg       <= '0;
            block_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            round_cnt_reg <= round_cnt_next;
            word_idx_reg  <= word_idx_next;
            pos_reg       <= pos_next;
            block_cnt_reg <= block_cnt_next;
        end
    end

    // block window and message schedule
    sha256bs_sched u_sched (
        .clk        (clk),
        .ctrl       (sched_ctrl),
        .byte_pos   (pos_reg),
        .data_byte  (data_byte),
        .total_bits (total_bits),
        .round_word (round_word)
    );

    // shared round unit and hash words
    sha256bs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (core_ctrl),
        .round_idx  (round_cnt_reg),
        .round_word (round_word),
        .word_idx   (word_idx_reg),
        .hash_word  (hash_word)
    );

    // a digest word is never shown while a byte can be taken
    a_idle_no_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("output valid while input side idle");

    // the last round always hands over to the hash add
    a_round_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == StRound && round_cnt_reg == 6'(RoundCount - 1))
        |=> state_reg == StUpdate)
        else $error("round sequence did not end in hash update");

    // a full block starts a compression at once
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == OpAbsorb && pos_reg == 6'd63)
        |=> (state_reg == StRound && round_cnt_reg == 6'd0 && pos_reg == 6'd0))
        else $error("full block did not start compression");

    // the eighth digest word returns the hasher to idle and the initial state
    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_accept && last_word)
        |=> (!in_stall && pos_reg == 6'd0 && block_cnt_reg == '0))
        else $error("hasher not idle after last digest word");

endmodule

FILE: tb/sv/sha256_byte_stream_hasher_unit_test.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_unit_test
// Self-checking bench for the SHA-256 byte stream hasher. Message bytes and
// finish words are driven from a queue with random gaps, digest words are
// taken under random back-pressure, and each digest word is compared with
// a SHA-256 model kept inside the bench, run on every accepted input word.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit_test;

    import sha256bs_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 4;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_BITS  = 512;

    localparam word_t ROUND_K [RoundCount] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t HASH_IV [HashWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } byte_item_t;

    typedef struct packed {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_entry_t;

    // dut ports
    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_stall;
    word_t      digest_word;
    logic [2:0] word_index;
    logic       last_word;

    // stimulus and expected digest words
    byte_item_t    byte_feed [$];
    digest_entry_t digest_expect [$];

    // model state
    word_t       hash_state [HashWords];
    word_t       block_buf [BlockWords];
    int          fill_pos;
    logic [63:0] msg_bits;

    // handshake bookkeeping
    bit in_taken;
    bit out_taken;
    int in_gap;
    int in_quiet;
    int out_hold;
    int out_quiet;
    int cycle_count;
    int fail_count;

    sha256_byte_stream_hasher_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // clock
    always #CLK_HALF clk = ~clk;

    function automatic word_t rotr(word_t x, int n);
        return (x >> n) | (x << (WordWidth - n));
    endfunction

    // one 64-round compression of block_buf into hash_state
    function automatic void compress_block();
        word_t w [RoundCount];
        word_t v [HashWords];
        word_t s0;
        word_t s1;
        word_t t1;
        word_t t2;
        for (int i = 0; i < RoundCount; i++)
        begin
            if (i < BlockWords)
                w[i] = block_buf[i];
            else
            begin
                s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
        end
        v = hash_state;
        for (int i = 0; i < RoundCount; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < HashWords; i++)
            hash_state[i] = hash_state[i] + v[i];
    endfunction

    // big-endian byte placement within the block
    function automatic void put_byte(int pos, logic [7:0] value);
        block_buf[pos / 4][(3 - pos % 4) * 8 +: 8] = value;
    endfunction

    function automatic void restart_message();
        hash_state = HASH_IV;
        fill_pos   = 0;
        msg_bits   = '0;
    endfunction

    // absorb a byte, or pad, compress and queue the eight digest words
    function automatic void hash_word_in(logic op_bit, logic [7:0] value);
        logic [63:0]   total_bits;
        digest_entry_t entry;
        if (op_bit == OP_ABSORB)
        begin
            put_byte(fill_pos, value);
            fill_pos++;
            if (fill_pos == BLOCK_BYTES)
            begin
                compress_block();
                msg_bits = msg_bits + BLOCK_BITS;
                fill_pos = 0;
            end
        end
        else
        begin
            total_bits = msg_bits + 64'(fill_pos) * 8;
            put_byte(fill_pos, PadByte);
            for (int p = fill_pos + 1; p < BLOCK_BYTES; p++)
                put_byte(p, 8'h00);
            // no room for the length: finish this block, length goes in a fresh one
            if (fill_pos >= LengthStart)
            begin
                compress_block();
                for (int i = 0; i < BlockWords; i++)
                    block_buf[i] = '0;
            end
            block_buf[14] = total_bits[63:32];
            block_buf[15] = total_bits[31:0];
            compress_block();
            for (int i = 0; i < HashWords; i++)
            begin
                entry.word  = hash_state[i];
                entry.index = 3'(i);
                entry.last  = (i == HashWords - 1);
                digest_expect.push_back(entry);
            end
            restart_message();
        end
    endfunction

    // per-word wait, with occasional stretches of no waiting at all
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        fail_count++;
    endtask

    task automatic add_item(logic op_bit, logic [7:0] value);
        byte_item_t item;
        item.op   = op_bit;
        item.data = value;
        byte_feed.push_back(item);
    endtask

    // random message of the given length, then a finish with junk data
    task automatic add_random_message(int len);
        for (int i = 0; i < len; i++)
            add_item(OP_ABSORB, 8'($urandom_range(0, 255)));
        add_item(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // acceptance on the input side feeds the model; cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sha256_byte_stream_hasher_unit_test: FAIL");
            $finish;
        end
        if (rst_n === 1'b1 && in_valid && !in_stall)
        begin
            hash_word_in(op, data_byte);
            in_taken = 1'b1;
        end
    end

    // monitor: compare each taken digest word with the oldest expectation
    always @(posedge clk)
    begin
        digest_entry_t want;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            out_taken = 1'b1;
            if (digest_expect.size() == 0)
                report_mismatch("unexpected digest word", digest_word, 32'h0);
            else
            begin
                want = digest_expect.pop_front();
                if (digest_word !== want.word)
                    report_mismatch("digest_word", digest_word, want.word);
                if (word_index !== want.index)
                    report_mismatch("word_index", 32'(word_index), 32'(want.index));
                if (last_word !== want.last)
                    report_mismatch("last_word", 32'(last_word), 32'(want.last));
            end
        end
    end

    // driver: present the next word after its drawn gap
    always @(negedge clk)
    begin
        byte_item_t item;
        if (rst_n === 1'b1 && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (byte_feed.size() > 0)
            begin
                item = byte_feed.pop_front();
                op        <= item.op;
                data_byte <= item.data;
                in_valid  <= 1'b1;
                in_gap = draw_wait(in_quiet);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver back-pressure: a fresh stall count after each taken word
    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                out_hold = draw_wait(out_quiet);
            end
            out_stall <= (out_hold > 0);
            if (out_hold > 0)
                out_hold--;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = OP_ABSORB;
        data_byte = 8'h00;
        out_stall = 1'b0;
        restart_message();

        // directed: empty message, byte extremes, "abc", ignored finish data
        add_item(OP_FINISH, 8'h00);
        add_item(OP_ABSORB, 8'h00);
        add_item(OP_FINISH, 8'hff);
        add_item(OP_ABSORB, 8'hff);
        add_item(OP_FINISH, 8'h00);
        add_item(OP_ABSORB, 8'h61);
        add_item(OP_ABSORB, 8'h62);
        add_item(OP_ABSORB, 8'h63);
        add_item(OP_FINISH, 8'h5a);
        add_item(OP_FINISH, 8'hff);

        // random: one full block, then fewer than nine bytes of room left,
        // so the length needs a second padded block
        add_random_message(BLOCK_BYTES + $urandom_range(56, 63));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_feed.size() != 0 || in_valid || digest_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && digest_expect.size() == 0)
            $display("sha256_byte_stream_hasher_unit_test: PASS");
        else
            $display("sha256_byte_stream_hasher_unit_test: FAIL");
        $finish;
    end

endmodule
